/* rtl/vbc_pkg.sv */
// shared types, constants and register codes for the beep cadence block
`default_nettype none
package vbc_pkg;

  localparam int unsigned ELAPSED_WIDTH_DEF = 16;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEPS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME      = 3'd0,
    REG_SINK_EN     = 3'd1,
    REG_DEAD_LOW    = 3'd2,
    REG_CLIMB_EDGE  = 3'd3,
    REG_CLIMB_FULL  = 3'd4,
    REG_SLOW_PERIOD = 3'd5,
    REG_FAST_PERIOD = 3'd6,
    REG_SINK_HALF   = 3'd7
  } cfg_idx_e;

  localparam logic [4:0]          VOLUME_RST      = 5'd10;
  localparam logic                SINK_EN_RST     = 1'b0;
  localparam logic signed [13:0]  DEAD_LOW_RST    = -14'sd300;
  localparam logic [12:0]         CLIMB_EDGE_RST  = 13'd150;
  localparam logic [14:0]         CLIMB_FULL_RST  = 15'd3000;
  localparam logic [15:0]         SLOW_PERIOD_RST = 16'd1000;
  localparam logic [15:0]         FAST_PERIOD_RST = 16'd150;
  localparam logic [15:0]         SINK_HALF_RST   = 16'd500;

  typedef struct packed {
    logic [4:0]  volume;
    logic        sink_en;
    logic [13:0] dead_low;
    logic [12:0] climb_edge;
    logic [14:0] climb_full;
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [15:0] sink_half;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_load;
    logic div_step;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/vbc_cfg.sv */
// configuration register bank
`default_nettype none
module vbc_cfg
  import vbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume      <= VOLUME_RST;
      cfg_q.sink_en     <= SINK_EN_RST;
      cfg_q.dead_low    <= DEAD_LOW_RST;
      cfg_q.climb_edge  <= CLIMB_EDGE_RST;
      cfg_q.climb_full  <= CLIMB_FULL_RST;
      cfg_q.slow_period <= SLOW_PERIOD_RST;
      cfg_q.fast_period <= FAST_PERIOD_RST;
      cfg_q.sink_half   <= SINK_HALF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_VOLUME:      cfg_q.volume      <= cfg_data_i[4:0];
        REG_SINK_EN:     cfg_q.sink_en     <= cfg_data_i[0];
        REG_DEAD_LOW:    cfg_q.dead_low    <= cfg_data_i[13:0];
        REG_CLIMB_EDGE:  cfg_q.climb_edge  <= cfg_data_i[12:0];
        REG_CLIMB_FULL:  cfg_q.climb_full  <= cfg_data_i[14:0];
        REG_SLOW_PERIOD: cfg_q.slow_period <= cfg_data_i;
        REG_FAST_PERIOD: cfg_q.fast_period <= cfg_data_i;
        REG_SINK_HALF:   cfg_q.sink_half   <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/vbc_ctrl.sv */
// sequencing controller for the beep cadence datapath
`default_nettype none
module vbc_ctrl
  import vbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  assign cmd_o.load     = in_valid_i && in_ready_o;
  assign cmd_o.mul      = (state_q == ST_MUL);
  assign cmd_o.div_load = (state_q == ST_LOAD);
  assign cmd_o.div_step = (state_q == ST_DIV);
  assign cmd_o.commit   = commit;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_STEPS - 1)) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/vbc_dp.sv */
// period interpolation, serial divider and beeper state
`default_nettype none
module vbc_dp
  import vbc_pkg::*;
#(
  parameter int unsigned ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire cmd_t                cmd_i,
  input  wire logic [SPEED_W-1:0]  vario_mms_i,
  input  wire logic                sample_invalid_i,
  output logic                     beeper_on_o
);

  localparam int unsigned CmpW = (ELAPSED_WIDTH > PERIOD_W) ? ELAPSED_WIDTH : PERIOD_W;

  logic signed [SPEED_W-1:0] v_q;
  logic [30:0]               prod_q;
  logic [14:0]               den_q;
  logic                      den_pos_q, d_neg_q;
  logic [14:0]               rem_q, rem_d;
  logic [15:0]               quo_q, quo_d;
  logic                      beep_q, beep_d;
  logic [ELAPSED_WIDTH-1:0]  el_q, el_d, el_inc;

  logic signed [16:0] den_w, num_w, d_w, d_abs_w;
  logic [14:0]        num_c;
  logic [31:0]        dividend;
  logic [16:0]        trial;
  logic [15:0]        period, on_ms, off_ms;
  logic signed [15:0] dl_ext, dh_ext;
  logic               in_dead, in_sink;
  logic [CmpW-1:0]    el_ext;

  // operand setup for the multiply
  always_comb begin
    den_w   = $signed({2'b00, cfg_i.climb_full}) - $signed({4'b0000, cfg_i.climb_edge});
    num_w   = $signed({v_q[15], v_q}) - $signed({4'b0000, cfg_i.climb_edge});
    d_w     = $signed({1'b0, cfg_i.slow_period}) - $signed({1'b0, cfg_i.fast_period});
    d_abs_w = d_w[16] ? -d_w : d_w;
    if (num_w[16]) begin
      num_c = '0;
    end else if (num_w > den_w) begin
      num_c = den_w[14:0];
    end else begin
      num_c = num_w[14:0];
    end
  end

  // ceiling for a shortening period, floor for a lengthening one
  assign dividend = d_neg_q ? {1'b0, prod_q}
                            : {1'b0, prod_q} + {17'd0, den_q} - 32'd1;

  assign trial = {1'b0, rem_q, quo_q[15]} - {2'b00, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_load) begin
      rem_d = dividend[30:16];
      quo_d = dividend[15:0];
    end else if (cmd_i.div_step) begin
      if (!trial[16]) begin
        rem_d = trial[14:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[13:0], quo_q[15]};
        quo_d = {quo_q[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!den_pos_q) begin
      period = cfg_i.fast_period;
    end else if (d_neg_q) begin
      period = cfg_i.slow_period + quo_q;
    end else begin
      period = cfg_i.slow_period - quo_q;
    end
    on_ms  = {1'b0, period[15:1]};
    off_ms = period - on_ms;
  end

  // beeper decision at commit
  always_comb begin
    el_inc  = (el_q == '1) ? el_q : el_q + 1'b1;
    el_ext  = CmpW'(el_inc);
    dl_ext  = $signed({{2{cfg_i.dead_low[13]}}, cfg_i.dead_low});
    dh_ext  = $signed({3'b000, cfg_i.climb_edge});
    in_sink = (v_q <= dl_ext);
    in_dead = (v_q > dl_ext) && (v_q < dh_ext);
    beep_d  = beep_q;
    el_d    = el_inc;
    if ((cfg_i.volume == '0) || in_dead) begin
      beep_d = 1'b0;
    end else if (in_sink) begin
      if (!cfg_i.sink_en) begin
        beep_d = 1'b0;
      end else if (el_ext >= CmpW'(cfg_i.sink_half)) begin
        beep_d = !beep_q;
        el_d   = '0;
      end
    end else if (beep_q) begin
      if (el_ext >= CmpW'(on_ms)) begin
        beep_d = 1'b0;
        el_d   = '0;
      end
    end else if (el_ext >= CmpW'(off_ms)) begin
      beep_d = 1'b1;
      el_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= sample_invalid_i ? '0 : $signed(vario_mms_i);
    end
    if (cmd_i.mul) begin
      prod_q    <= {16'd0, num_c} * {15'd0, d_abs_w[15:0]};
      den_q     <= den_w[14:0];
      den_pos_q <= !den_w[16] && (den_w != '0);
      d_neg_q   <= d_w[16];
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_q <= 1'b0;
      el_q   <= '0;
    end else if (cmd_i.commit) begin
      beep_q <= beep_d;
      el_q   <= el_d;
    end
  end

  assign beeper_on_o = beep_q;

endmodule
`default_nettype wire

/* rtl/vario_beep_cadence_core.sv */
// flow: after an input word is accepted the controller steps through its states in order
// (1 multiply, 1 dividend load, 16 restoring divider steps, 1 commit); out_valid_o is registered at the commit
// a new word is taken only in idle, after the previous word is committed, and the commit
// waits while an earlier output word is still held back by out_ready_i
// reset: config returns to defaults, beeper low, elapsed count zero, no word pending
`default_nettype none
module vario_beep_cadence_core
  import vbc_pkg::*;
#(
  parameter int unsigned ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [SPEED_W-1:0]    vario_mms_i,
  input  wire logic                  sample_invalid_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       beeper_on_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  cmd_t cmd;

  vbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  vbc_dp #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .vario_mms_i      (vario_mms_i),
    .sample_invalid_i (sample_invalid_i),
    .beeper_on_o      (beeper_on_o)
  );

endmodule
`default_nettype wire

/* rtl/vbc_checker.sv */
// port-level checker for the beep cadence core and its bind
`default_nettype none
module vbc_checker
  import vbc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [SPEED_W-1:0]    vario_mms_i,
  input wire logic                  sample_invalid_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic                  beeper_on_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(beeper_on_o))
    else $error("output word changed while stalled");

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // a result only appears at the end of a computation
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word without a computation");

  // no result the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result word too early");

endmodule

bind vario_beep_cadence_core vbc_checker u_vbc_checker (.*);
`default_nettype wire

/* sim/vbc_cadence_checker.sv */
// beep cadence checker: follows the channels, predicts each beeper word and compares
`timescale 1ns / 1ps
module vbc_cadence_checker
  import vbc_pkg::*;
#(
  parameter int unsigned ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SPEED_W-1:0]    vario_mms_i,
  input  logic                  sample_invalid_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  beeper_on_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fails_o,
  output int                    pending_o
);

  logic [4:0]               volume;
  logic                     sink_en;
  logic signed [13:0]       dead_low;
  logic [12:0]              climb_edge;
  logic [14:0]              climb_full;
  logic [15:0]              slow_period;
  logic [15:0]              fast_period;
  logic [15:0]              sink_half;
  logic                     beep_level;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms;
  logic                     level_q[$];
  logic                     expected_level;
  int                       n_fail;

  function automatic logic [15:0] climb_period(input longint speed);
    longint den, num, span, cut;
    den  = longint'(climb_full) - longint'(climb_edge);
    num  = speed - longint'(climb_edge);
    span = longint'(slow_period) - longint'(fast_period);
    if (den <= 0) begin
      return fast_period;
    end
    if (num < 0) num = 0;
    if (num > den) num = den;
    // round the subtracted part up, towards the fast end when slow is not below fast
    if (span >= 0) begin
      cut = (num * span + den - 1) / den;
    end else begin
      cut = -((num * (-span)) / den);
    end
    return 16'(longint'(slow_period) - cut);
  endfunction

  function automatic logic cadence_tick(input logic [15:0] mms, input logic invalid);
    longint      speed;
    logic [15:0] period;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    speed = invalid ? 64'sd0 : longint'($signed(mms));
    if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
    if (volume == '0 || (speed > longint'(dead_low) && speed < longint'(climb_edge))) begin
      beep_level = 1'b0;
    end else if (speed <= longint'(dead_low)) begin
      if (!sink_en) begin
        beep_level = 1'b0;
      end else if (elapsed_ms >= sink_half) begin
        beep_level = ~beep_level;
        elapsed_ms = '0;
      end
    end else begin
      period = climb_period(speed);
      on_ms  = period >> 1;
      off_ms = period - on_ms;
      if (beep_level) begin
        if (elapsed_ms >= on_ms) begin
          beep_level = 1'b0;
          elapsed_ms = '0;
        end
      end else if (elapsed_ms >= off_ms) begin
        beep_level = 1'b1;
        elapsed_ms = '0;
      end
    end
    return beep_level;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume      = VOLUME_RST;
      sink_en     = SINK_EN_RST;
      dead_low    = DEAD_LOW_RST;
      climb_edge  = CLIMB_EDGE_RST;
      climb_full  = CLIMB_FULL_RST;
      slow_period = SLOW_PERIOD_RST;
      fast_period = FAST_PERIOD_RST;
      sink_half   = SINK_HALF_RST;
      beep_level  = 1'b0;
      elapsed_ms  = '0;
      level_q.delete();
      n_fail      = 0;
      fails_o     <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_VOLUME:      volume      = cfg_data_i[4:0];
          REG_SINK_EN:     sink_en     = cfg_data_i[0];
          REG_DEAD_LOW:    dead_low    = cfg_data_i[13:0];
          REG_CLIMB_EDGE:  climb_edge  = cfg_data_i[12:0];
          REG_CLIMB_FULL:  climb_full  = cfg_data_i[14:0];
          REG_SLOW_PERIOD: slow_period = cfg_data_i;
          REG_FAST_PERIOD: fast_period = cfg_data_i;
          REG_SINK_HALF:   sink_half   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        level_q.push_back(cadence_tick(vario_mms_i, sample_invalid_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (level_q.size() == 0) begin
          n_fail++;
          $display("%0t: beeper word with none due, expected none, actual %0b",
                   $time, beeper_on_i);
        end else begin
          expected_level = level_q.pop_front();
          if (expected_level !== beeper_on_i) begin
            n_fail++;
            $display("%0t: beeper_on mismatch, expected %0b, actual %0b",
                     $time, expected_level, beeper_on_i);
          end
        end
      end
      fails_o   <= n_fail;
      pending_o <= level_q.size();
    end
  end

endmodule

/* sim/vario_beep_cadence_core_tb.sv */
// testbench top for the beep cadence core: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps
module vario_beep_cadence_core_tb;
  import vbc_pkg::*;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [SPEED_W-1:0]    vario_mms      = '0;
  logic                  sample_invalid = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  beeper_on;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  int                    fails;
  int                    pending;
  int                    stall_pct      = 30;
  int                    hold           = 0;
  int                    cur_dlo        = -300;
  int                    cur_dhi        = 150;
  int                    cur_cfull      = 3000;

  always #6 clk = ~clk;

  vario_beep_cadence_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .vario_mms_i      (vario_mms),
    .sample_invalid_i (sample_invalid),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .beeper_on_o      (beeper_on),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  vbc_cadence_checker #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH_DEF)
  ) u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .vario_mms_i      (vario_mms),
    .sample_invalid_i (sample_invalid),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .beeper_on_i      (beeper_on),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fails_o          (fails),
    .pending_o        (pending)
  );

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (hold > 0) begin
      hold <= hold - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      hold      <= $urandom_range(8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [15:0] mms, input logic invalid);
    if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    vario_mms      <= mms;
    sample_invalid <= invalid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_cadence(input int vol, input int sink, input int dlo, input int dhi,
                             input int cfull, input int slow, input int fast,
                             input int half);
    wait_drained();
    write_reg(REG_VOLUME, 16'(vol));
    write_reg(REG_SINK_EN, 16'(sink));
    write_reg(REG_DEAD_LOW, 16'(dlo));
    write_reg(REG_CLIMB_EDGE, 16'(dhi));
    write_reg(REG_CLIMB_FULL, 16'(cfull));
    write_reg(REG_SLOW_PERIOD, 16'(slow));
    write_reg(REG_FAST_PERIOD, 16'(fast));
    write_reg(REG_SINK_HALF, 16'(half));
    cfg_valid <= 1'b0;
    cur_dlo   = dlo;
    cur_dhi   = dhi;
    cur_cfull = cfull;
  endtask

  // speed around which a run of ticks is held
  function automatic int pick_centre();
    int lo_c, hi_c;
    lo_c = (cur_dhi < cur_cfull) ? cur_dhi : cur_cfull;
    hi_c = ((cur_dhi > cur_cfull) ? cur_dhi : cur_cfull) + 300;
    case ($urandom_range(7))
      0: return cur_dlo + int'($urandom_range(6)) - 3;
      1: return cur_dhi + int'($urandom_range(6)) - 3;
      2, 3: return lo_c + int'($urandom_range(hi_c - lo_c));
      4: return cur_dlo - int'($urandom_range(3000));
      5: return (cur_dhi > cur_dlo) ? cur_dlo + int'($urandom_range(cur_dhi - cur_dlo))
                                     : cur_dhi;
      6: return int'($signed(16'($urandom)));
      default: return int'($urandom_range(40000)) - 20000;
    endcase
  endfunction

  task automatic run_phase(input int n);
    int          done;
    int          len;
    int          centre;
    int          v;
    logic [15:0] mms;
    logic        invalid;
    done = 0;
    while (done < n) begin
      if ($urandom_range(19) == 0) wait_drained();
      centre = pick_centre();
      len    = $urandom_range(40, 3);
      for (int k = 0; k < len && done < n; k++) begin
        v = centre + int'($urandom_range(4)) - 2;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        mms     = 16'(v);
        invalid = ($urandom_range(11) == 0);
        if (invalid || $urandom_range(29) == 0) mms = 16'($urandom);
        send_word(mms, invalid);
        done++;
      end
    end
  endtask

  initial begin
    int probe_mms[11];
    int dhi;
    int guard;
    probe_mms = '{32767, -32768, 32767, 20000, -20000, -300, -299, 149, 150, 3000, 3001};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and dead band edges at the reset settings, first one invalid
    foreach (probe_mms[i]) send_word(16'(probe_mms[i]), i == 0);

    // short sink tone then fast climb cadence
    set_cadence(20, 1, -300, 150, 3000, 8, 4, 2);
    repeat (6) send_word(-16'sd1000, 1'b0);
    repeat (8) send_word(16'sd5000, 1'b0);

    // zero on, off and sink half times
    set_cadence(20, 1, -300, 150, 3000, 0, 0, 0);
    run_phase(100);
    // crossed dead band
    set_cadence(5, 1, 8191, 0, 4000, 30, 4, 3);
    run_phase(100);
    // full rate not above the dead edge
    set_cadence(12, 1, -200, 5000, 4000, 50, 7, 4);
    run_phase(100);
    // fast period longer than slow
    set_cadence(31, 1, -500, 100, 2000, 6, 40, 9);
    run_phase(100);
    // silenced
    set_cadence(0, 1, -300, 150, 3000, 10, 4, 3);
    run_phase(60);
    // widest register values
    stall_pct = 50;
    set_cadence(31, 1, -8192, 8191, 32767, 65535, 2, 65535);
    run_phase(80);

    for (int p = 0; p < 8; p++) begin
      stall_pct = 25 * $urandom_range(2);
      dhi       = $urandom_range(2000);
      set_cadence(($urandom_range(9) == 0) ? 0 : $urandom_range(31, 1), $urandom_range(1),
                  -int'($urandom_range(2000)), dhi, dhi + $urandom_range(8000, 1),
                  $urandom_range(60, 2), $urandom_range(60, 2), $urandom_range(20));
      run_phase(95);
    end

    // closing stretch at full rate
    stall_pct = 0;
    set_cadence(16, 1, -400, 200, 2500, 24, 6, 5);
    run_phase(120);

    in_valid <= 1'b0;
    @(posedge clk);
    for (guard = 0; guard < 20000 && pending != 0; guard++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("vario_beep_cadence_core_tb OK");
    end else begin
      $display("vario_beep_cadence_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("vario_beep_cadence_core_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/vbc_pkg.sv
rtl/vbc_cfg.sv
rtl/vbc_ctrl.sv
rtl/vbc_dp.sv
rtl/vario_beep_cadence_core.sv
rtl/vbc_checker.sv
sim/vbc_cadence_checker.sv
sim/vario_beep_cadence_core_tb.sv
